FILE: rtl/piecewise_polynomial_evaluator_macros.svh
// assertion macros for the piecewise polynomial evaluator
`ifndef PIECEWISE_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define PIECEWISE_POLYNOMIAL_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PPE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PPE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/ppe_pkg.sv
`default_nettype none
package ppe_pkg;
    localparam int MAX_KNOTS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int IDX_W      = 4;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_EVAL_MODE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KNOT_COUNT     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_ENABLE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR_VALUE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CEILING_ENABLE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CEILING_VALUE  = 3'd6;

    localparam logic [1:0] MODE_STEP  = 2'd0;
    localparam logic [1:0] MODE_LIN   = 2'd1;
    localparam logic [1:0] MODE_QUAD  = 2'd2;
    localparam logic [1:0] MODE_CUBIC = 2'd3;

    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/piecewise_polynomial_evaluator.sv
// throughput: one beat per cycle while the output is not stalled; write beats produce no result
// stalls freeze the whole pipeline, nothing is lost or repeated
// reset: synchronous active-low aresetn clears valid bits and resets the config registers
// knot tables are undefined until written and are not cleared
`default_nettype none
`include "piecewise_polynomial_evaluator_macros.svh"
module piecewise_polynomial_evaluator #(
    parameter int MAX_KNOTS  = ppe_pkg::MAX_KNOTS,
    parameter int DATA_WIDTH = ppe_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = ppe_pkg::FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[3:0], knot_x, knot_y, coef_zero, coef_one, coef_two, coef_three,
    // x_value, zero fill to 232 bits
    input  wire logic [231:0] s_tdata,
    // command
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // y_value[31:0], segment_index[35:32], region[37:36], limited[38], zero fill
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int FW   = ppe_pkg::FIELD_W;
    localparam int SATB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int AW   = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int NS   = 10;
    localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (SATB-1)) - 1);
    localparam logic signed [FW-1:0] SAT_LO = FW'(-(64'sd1 <<< (SATB-1)));
    localparam logic [4:0] KC_MAX = 5'((MAX_KNOTS > 16) ? 16 : MAX_KNOTS);
    localparam logic [3:0] SC_MAX = 4'((MAX_KNOTS - 1 > 15) ? 15 : MAX_KNOTS - 1);

    typedef struct packed {
        logic [1:0]           region;
        logic [3:0]           seg;
        logic                 lim;
        logic [1:0]           steps;
        logic signed [FW-1:0] x;
        logic signed [FW-1:0] y;
        logic signed [FW-1:0] c2;
        logic signed [FW-1:0] c1;
        logic signed [FW-1:0] c0;
    } stage_t;

    logic [1:0]           eval_mode_reg;
    logic [4:0]           knot_count_reg;
    logic [3:0]           segment_count_reg;
    logic                 floor_enable_reg, ceiling_enable_reg;
    logic signed [FW-1:0] floor_value_reg, ceiling_value_reg;

    logic signed [FW-1:0] kx_mem [MAX_KNOTS];
    logic signed [FW-1:0] ky_mem [MAX_KNOTS];
    logic [4*FW-1:0]      cf_mem [MAX_KNOTS];

    logic                 adv;
    logic                 v_reg [NS];
    logic                 ev_in;
    logic [3:0]           widx;
    logic signed [FW-1:0] xin;

    logic                 wr_pend_reg;
    logic [3:0]           wr_idx_reg;
    logic [6*FW-1:0]      wr_data_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign ev_in     = s_tvalid && s_tready && (s_tuser == ppe_pkg::CMD_EVAL);
    assign widx      = s_tdata[3:0];
    assign xin       = s_tdata[4+6*FW +: FW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_mode_reg      <= ppe_pkg::MODE_QUAD;
            knot_count_reg     <= 5'd2;
            segment_count_reg  <= 4'd1;
            floor_enable_reg   <= 1'b0;
            floor_value_reg    <= '0;
            ceiling_enable_reg <= 1'b0;
            ceiling_value_reg  <= FW'(65536);
        end else if (cfg_valid) begin
            case (cfg_index)
                ppe_pkg::REG_EVAL_MODE:      eval_mode_reg      <= cfg_data[1:0];
                ppe_pkg::REG_KNOT_COUNT:     knot_count_reg     <= cfg_data[4:0];
                ppe_pkg::REG_SEGMENT_COUNT:  segment_count_reg  <= cfg_data[3:0];
                ppe_pkg::REG_FLOOR_ENABLE:   floor_enable_reg   <= cfg_data[0];
                ppe_pkg::REG_FLOOR_VALUE:    floor_value_reg    <= cfg_data;
                ppe_pkg::REG_CEILING_ENABLE: ceiling_enable_reg <= cfg_data[0];
                ppe_pkg::REG_CEILING_VALUE:  ceiling_value_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // write beats are registered before they land so evaluates already in flight read the old entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else if (adv) begin
            wr_pend_reg <= s_tvalid && (s_tuser == ppe_pkg::CMD_WRITE)
                           && (32'(widx) < MAX_KNOTS);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            wr_idx_reg  <= widx;
            wr_data_reg <= s_tdata[4 +: 6*FW];
        end
    end

    // table write; small enough to stay in flops, read per segment in parallel
    always_ff @(posedge aclk) begin
        if (adv && wr_pend_reg) begin
            kx_mem[AW'(wr_idx_reg)] <= wr_data_reg[0 +: FW];
            ky_mem[AW'(wr_idx_reg)] <= wr_data_reg[FW +: FW];
            cf_mem[AW'(wr_idx_reg)] <= wr_data_reg[2*FW +: 4*FW];
        end
    end

    // stage 0: clamp counts, capture x
    logic [4:0]           kc_w;
    logic [3:0]           sc_w;
    logic signed [FW-1:0] x0_reg;
    logic [AW-1:0]        kl0_reg;
    logic [3:0]           sc0_reg;
    always_comb begin
        kc_w = (knot_count_reg < 5'd2) ? 5'd2 :
               (knot_count_reg > KC_MAX) ? KC_MAX : knot_count_reg;
        sc_w = (segment_count_reg == 4'd0) ? 4'd1 :
               (segment_count_reg > SC_MAX) ? SC_MAX : segment_count_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg  <= xin;
            kl0_reg <= AW'(kc_w - 5'd1);
            sc0_reg <= sc_w;
        end
    end

    // stage 1: compare against every knot
    logic [MAX_KNOTS-1:0] gt1_reg;
    logic                 below1_reg, above1_reg;
    logic signed [FW-1:0] x1_reg;
    logic [3:0]           sc1_reg;
    logic [AW-1:0]        kl1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < MAX_KNOTS; i++) gt1_reg[i] <= (kx_mem[i] > x0_reg);
            below1_reg <= (x0_reg <= kx_mem[0]);
            above1_reg <= (x0_reg >= kx_mem[kl0_reg]);
            x1_reg     <= x0_reg;
            sc1_reg    <= sc0_reg;
            kl1_reg    <= kl0_reg;
        end
    end

    // stage 2: pick segment and fetch operands
    logic [3:0] seg_w;
    always_comb begin
        seg_w = 4'd0;
        for (int i = 1; i < 16; i++)
            if (i < MAX_KNOTS && 4'(i) < sc1_reg && !gt1_reg[i]) seg_w = 4'(i);
    end
    stage_t st_reg [4];
    logic signed [FW-1:0] lead2_w, ky_sel_w;
    logic [4*FW-1:0]      cf_w;
    always_comb begin
        cf_w     = cf_mem[AW'(seg_w)];
        ky_sel_w = ky_mem[AW'(seg_w)];
        case (eval_mode_reg)
            ppe_pkg::MODE_LIN:   lead2_w = cf_w[FW +: FW];
            ppe_pkg::MODE_QUAD:  lead2_w = cf_w[2*FW +: FW];
            ppe_pkg::MODE_CUBIC: lead2_w = cf_w[3*FW +: FW];
            default:             lead2_w = ky_sel_w;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0].x  <= x1_reg;
            st_reg[0].c0 <= cf_w[0 +: FW];
            st_reg[0].c1 <= cf_w[FW +: FW];
            st_reg[0].c2 <= cf_w[2*FW +: FW];
            st_reg[0].lim <= 1'b0;
            if (below1_reg) begin
                st_reg[0].region <= ppe_pkg::REGION_BELOW;
                st_reg[0].seg    <= 4'd0;
                st_reg[0].y      <= ky_mem[0];
                st_reg[0].steps  <= 2'd0;
            end else if (above1_reg) begin
                st_reg[0].region <= ppe_pkg::REGION_ABOVE;
                st_reg[0].seg    <= 4'd0;
                st_reg[0].y      <= ky_mem[kl1_reg];
                st_reg[0].steps  <= 2'd0;
            end else begin
                st_reg[0].region <= ppe_pkg::REGION_INSIDE;
                st_reg[0].seg    <= seg_w;
                st_reg[0].y      <= lead2_w;
                st_reg[0].steps  <= eval_mode_reg;
            end
        end
    end

    // horner: three steps, each a multiply stage and an add/saturate stage
    logic signed [2*FW-1:0] prod_reg [3];
    stage_t                 ps_reg   [3];
    for (genvar j = 0; j < 3; j++) begin : g_horner
        logic                   act_w;
        logic signed [2*FW-1:0] sh_w;
        logic signed [2*FW:0]   sum_w;
        logic signed [FW-1:0]   cadd_w;
        logic signed [FW-1:0]   ysat_w;
        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[j] <= st_reg[j].y * st_reg[j].x;
                ps_reg[j]   <= st_reg[j];
            end
        end
        always_comb begin
            act_w  = (ps_reg[j].steps != 2'd0);
            cadd_w = (ps_reg[j].steps == 2'd3) ? ps_reg[j].c2 :
                     (ps_reg[j].steps == 2'd2) ? ps_reg[j].c1 : ps_reg[j].c0;
            sh_w   = prod_reg[j] >>> FRAC_BITS;
            sum_w  = (2*FW+1)'(sh_w) + (2*FW+1)'(cadd_w);
            if (sum_w > (2*FW+1)'(SAT_HI))      ysat_w = SAT_HI;
            else if (sum_w < (2*FW+1)'(SAT_LO)) ysat_w = SAT_LO;
            else                                ysat_w = FW'(sum_w);
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[j+1] <= ps_reg[j];
                if (act_w) begin
                    st_reg[j+1].y     <= ysat_w;
                    st_reg[j+1].lim   <= ps_reg[j].lim || (ysat_w != FW'(sum_w))
                                         || (sum_w != (2*FW+1)'(ysat_w));
                    st_reg[j+1].steps <= ps_reg[j].steps - 2'd1;
                end
            end
        end
    end

    // output stage: clamps and final saturation
    logic signed [FW-1:0] yo_w;
    logic                 lo_w;
    logic [FW-1:0]        y_out_reg;
    logic [3:0]           seg_out_reg;
    logic [1:0]           reg_out_reg;
    logic                 lim_out_reg;
    always_comb begin
        yo_w = st_reg[3].y;
        lo_w = st_reg[3].lim;
        if (yo_w > SAT_HI) begin yo_w = SAT_HI; lo_w = 1'b1; end
        else if (yo_w < SAT_LO) begin yo_w = SAT_LO; lo_w = 1'b1; end
        if (floor_enable_reg && yo_w < floor_value_reg) begin
            yo_w = floor_value_reg; lo_w = 1'b1;
        end else if (ceiling_enable_reg && yo_w > ceiling_value_reg) begin
            yo_w = ceiling_value_reg; lo_w = 1'b1;
        end
        if (yo_w > SAT_HI) begin yo_w = SAT_HI; lo_w = 1'b1; end
        else if (yo_w < SAT_LO) begin yo_w = SAT_LO; lo_w = 1'b1; end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            y_out_reg   <= yo_w;
            seg_out_reg <= st_reg[3].seg;
            reg_out_reg <= st_reg[3].region;
            lim_out_reg <= lo_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= ev_in;
            for (int i = 1; i < NS; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {1'b0, lim_out_reg, reg_out_reg, seg_out_reg, y_out_reg};

    `PPE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PPE_ASSERT_IMPL(a_ready, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    `PPE_ASSERT_IMPL(a_region, aclk, aresetn, m_tvalid, m_tdata[37:36] != 2'd3)
    `PPE_ASSERT_IMPL(a_seg, aclk, aresetn,
        m_tvalid && m_tdata[37:36] != ppe_pkg::REGION_INSIDE, m_tdata[35:32] == 4'd0)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        limited;
        logic [1:0]  region;
        logic [3:0]  seg;
        logic [31:0] y;
    } spline_result_t;

    typedef struct {
        logic [31:0]    x;
        bit             known;
        spline_result_t res;
    } probe_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [231:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    piecewise_polynomial_evaluator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of tables and registers
    logic signed [31:0] knot_x_sh [ppe_pkg::MAX_KNOTS];
    logic signed [31:0] knot_y_sh [ppe_pkg::MAX_KNOTS];
    logic signed [31:0] coef_sh   [ppe_pkg::MAX_KNOTS][4];
    logic [1:0]  mode_sh;
    logic [4:0]  knots_sh;
    logic [3:0]  segs_sh;
    logic        floor_en_sh, ceil_en_sh;
    logic [31:0] floor_sh, ceil_sh;

    spline_result_t pending_results[$];
    int tx_pct = 0, rx_pct = 0;
    int hold_gen = 0, hold_seen = 0, hold_cnt = 0;
    int mismatches = 0, results_seen = 0, evals_sent = 0, loads_sent = 0;
    int idle_cycles = 0;

    function automatic longint sat32(longint v, inout bit lim);
        if (v > 64'sd2147483647) begin
            lim = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            lim = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic spline_result_t predict_point(logic signed [31:0] xv);
        longint x, y;
        int kc, sc, seg, k;
        bit lim;
        spline_result_t r;
        x = xv;
        lim = 1'b0;
        seg = 0;
        kc = knots_sh;
        if (kc < 2) kc = 2;
        if (kc > ppe_pkg::MAX_KNOTS) kc = ppe_pkg::MAX_KNOTS;
        sc = segs_sh;
        if (sc < 1) sc = 1;
        if (sc > ppe_pkg::MAX_KNOTS - 1) sc = ppe_pkg::MAX_KNOTS - 1;
        if (x <= knot_x_sh[0]) begin
            r.region = ppe_pkg::REGION_BELOW;
            y = knot_y_sh[0];
        end else if (x >= knot_x_sh[kc-1]) begin
            r.region = ppe_pkg::REGION_ABOVE;
            y = knot_y_sh[kc-1];
        end else begin
            r.region = ppe_pkg::REGION_INSIDE;
            seg = sc - 1;
            while (seg > 0 && knot_x_sh[seg] > x) seg--;
            if (mode_sh == ppe_pkg::MODE_STEP) begin
                y = knot_y_sh[seg];
            end else begin
                k = mode_sh;
                y = coef_sh[seg][k];
                for (k = k - 1; k >= 0; k--)
                    y = sat32(((y * x) >>> ppe_pkg::FRAC_BITS) + coef_sh[seg][k], lim);
            end
        end
        if (floor_en_sh && y < longint'(signed'(floor_sh))) begin
            y = signed'(floor_sh);
            lim = 1'b1;
        end else if (ceil_en_sh && y > longint'(signed'(ceil_sh))) begin
            y = signed'(ceil_sh);
            lim = 1'b1;
        end
        y = sat32(y, lim);
        r.y = y[31:0];
        r.seg = seg[3:0];
        r.limited = lim;
        return r;
    endfunction

    function automatic logic [231:0] pack_load(logic [3:0] idx, logic [31:0] kx, logic [31:0] ky,
                                               logic [31:0] c0, logic [31:0] c1,
                                               logic [31:0] c2, logic [31:0] c3);
        return {4'b0, $urandom(), c3, c2, c1, c0, ky, kx, idx};
    endfunction

    function automatic logic [231:0] pack_eval(logic [31:0] xv);
        logic [231:0] d;
        d = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom()};
        d[231:228] = 4'b0;
        d[227:196] = xv;
        return d;
    endfunction

    task automatic send_beat(logic cmd, logic [231:0] d);
        while ($urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == ppe_pkg::CMD_EVAL) begin
            pending_results.push_back(predict_point(d[227:196]));
            evals_sent++;
        end else begin
            knot_x_sh[d[3:0]] = d[35:4];
            knot_y_sh[d[3:0]] = d[67:36];
            coef_sh[d[3:0]][0] = d[99:68];
            coef_sh[d[3:0]][1] = d[131:100];
            coef_sh[d[3:0]][2] = d[163:132];
            coef_sh[d[3:0]][3] = d[195:164];
            loads_sent++;
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            ppe_pkg::REG_EVAL_MODE:      mode_sh = val[1:0];
            ppe_pkg::REG_KNOT_COUNT:     knots_sh = val[4:0];
            ppe_pkg::REG_SEGMENT_COUNT:  segs_sh = val[3:0];
            ppe_pkg::REG_FLOOR_ENABLE:   floor_en_sh = val[0];
            ppe_pkg::REG_FLOOR_VALUE:    floor_sh = val;
            ppe_pkg::REG_CEILING_ENABLE: ceil_en_sh = val[0];
            ppe_pkg::REG_CEILING_VALUE:  ceil_sh = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] md, logic [31:0] kc, logic [31:0] sc, logic [31:0] fe,
                             logic [31:0] fv, logic [31:0] ce, logic [31:0] cv);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        write_reg(ppe_pkg::REG_EVAL_MODE, md);
        write_reg(ppe_pkg::REG_KNOT_COUNT, kc);
        write_reg(ppe_pkg::REG_SEGMENT_COUNT, sc);
        write_reg(ppe_pkg::REG_FLOOR_ENABLE, fe);
        write_reg(ppe_pkg::REG_FLOOR_VALUE, fv);
        write_reg(ppe_pkg::REG_CEILING_ENABLE, ce);
        write_reg(ppe_pkg::REG_CEILING_VALUE, cv);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ascending knots with random spacing and random content
    task automatic load_random_table(bit wide);
        logic signed [31:0] kx;
        logic [31:0] c [4];
        kx = wide ? -$signed($urandom_range(32'h7000_0000)) : -$signed($urandom_range(32'h0008_0000));
        for (int i = 0; i < ppe_pkg::MAX_KNOTS; i++) begin
            for (int k = 0; k < 4; k++)
                c[k] = ($urandom_range(3) == 0) ? $urandom() : $signed($urandom_range(32'h3_ffff)) - 32'sh2_0000;
            send_beat(ppe_pkg::CMD_WRITE, pack_load(i[3:0], kx, $urandom(), c[0], c[1], c[2], c[3]));
            kx = kx + (wide ? $urandom_range(32'h0C00_0000, 1) : $urandom_range(32'h0003_0000, 1));
        end
    endtask

    task automatic random_point();
        logic signed [31:0] lo, hi;
        int kc;
        kc = (knots_sh < 2) ? 2 : (knots_sh > ppe_pkg::MAX_KNOTS ? ppe_pkg::MAX_KNOTS : knots_sh);
        lo = knot_x_sh[0];
        hi = knot_x_sh[kc-1];
        case ($urandom_range(9))
            0: send_beat(ppe_pkg::CMD_EVAL, pack_eval($urandom()));
            1: send_beat(ppe_pkg::CMD_EVAL,
                         pack_eval(knot_x_sh[$urandom_range(ppe_pkg::MAX_KNOTS-1)]));
            2: send_beat(ppe_pkg::CMD_EVAL, pack_eval(lo - $urandom_range(3)));
            3: send_beat(ppe_pkg::CMD_EVAL, pack_eval(hi + $urandom_range(3)));
            default: begin
                if (hi > lo)
                    send_beat(ppe_pkg::CMD_EVAL,
                              pack_eval(32'(longint'(lo) +
                                            longint'($urandom()) % (longint'(hi) - lo))));
                else
                    send_beat(ppe_pkg::CMD_EVAL, pack_eval($urandom()));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (hold_gen != hold_seen) begin
            hold_seen <= hold_gen;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rx_pct);
        end
    end

    always @(posedge aclk) begin
        spline_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[38:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.y !== want.y || got.seg !== want.seg || got.region !== want.region ||
                    got.limited !== want.limited) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp y=%h seg=%0d reg=%0d lim=%0d, got y=%h seg=%0d reg=%0d lim=%0d",
                                 want.y, want.seg, want.region, want.limited,
                                 got.y, got.seg, got.region, got.limited);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    probe_row_t probes[$];

    initial begin
        int drain;
        mode_sh = ppe_pkg::MODE_QUAD;
        knots_sh = 5'd2;
        segs_sh = 4'd1;
        floor_en_sh = 1'b0;
        floor_sh = 32'd0;
        ceil_en_sh = 1'b0;
        ceil_sh = 32'd65536;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // known table: knot i at x = i, knot 0 at the most negative ordinate
        for (int i = 0; i < ppe_pkg::MAX_KNOTS; i++)
            send_beat(ppe_pkg::CMD_WRITE,
                      pack_load(i[3:0], i << 16, (i == 0) ? 32'h8000_0000 : i * 1000,
                                $urandom(), $urandom(), $urandom(), $urandom()));
        probes.push_back('{32'h8000_0000, 1,
                           '{1'b0, ppe_pkg::REGION_BELOW, 4'd0, 32'h8000_0000}});
        probes.push_back('{32'h7fff_ffff, 1, '{1'b0, ppe_pkg::REGION_ABOVE, 4'd0, 32'd1000}});
        probes.push_back('{32'h0000_0000, 1,
                           '{1'b0, ppe_pkg::REGION_BELOW, 4'd0, 32'h8000_0000}});
        probes.push_back('{32'h0001_0000, 1, '{1'b0, ppe_pkg::REGION_ABOVE, 4'd0, 32'd1000}});
        probes.push_back('{32'h0000_0001, 0, '0});
        probes.push_back('{32'h0000_8000, 0, '0});
        probes.push_back('{32'h0000_ffff, 0, '0});
        foreach (probes[i]) begin
            send_beat(ppe_pkg::CMD_EVAL, pack_eval(probes[i].x));
            if (probes[i].known) pending_results[$] = probes[i].res;
        end
        end_burst();

        for (int ph = 0; ph < 9; ph++) begin
            tx_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 59 : 18) : 0;
            rx_pct = (ph % 4 == 2) ? 59 : ((ph % 4 == 3) ? 18 : 0);
            case (ph)
                0: configure(32'(ppe_pkg::MODE_STEP), 16, 15, 0, 0, 0, 0);
                1: configure(32'(ppe_pkg::MODE_CUBIC), 31, 0, 1, 32'h8000_0000, 1,
                             32'h7fff_ffff);
                2: configure(32'(ppe_pkg::MODE_LIN), 0, 15, 1, 32'h7fff_ffff, 0,
                             32'h8000_0000);
                3: configure(32'(ppe_pkg::MODE_CUBIC), 16, 15, 0, 32'hffff_0000, 1,
                             32'h8000_0000);
                default: configure($urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom());
            endcase
            load_random_table(ph % 2);
            if (ph == 4) hold_gen++;
            for (int n = 0; n < 36; n++) begin
                if ($urandom_range(99) < 12)
                    send_beat(ppe_pkg::CMD_WRITE,
                              pack_load($urandom(), $urandom(), $urandom(), $urandom(),
                                        $urandom(), $urandom(), $urandom()));
                else
                    random_point();
                if ($urandom_range(99) < 3) load_random_table($urandom_range(1));
            end
            end_burst();
        end

        drain = 0;
        while (pending_results.size() != 0 && drain < IDLE_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d knot loads and %0d evaluations over 9 register settings",
                 loads_sent, evals_sent);
        $display("%0d result beats checked, %0d mismatches, %0d left pending",
                 results_seen, mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
